FILE: src/prefix_code_table_decoder_macros.svh
// Assertion helpers for the decoder.
`ifndef PREFIX_CODE_TABLE_DECODER_MACROS_SVH
`define PREFIX_CODE_TABLE_DECODER_MACROS_SVH

// same-cycle implication, clocked on i_clk, off while i_rst_n is low
`define PCTD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off while i_rst_n is low
`define PCTD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/pctd_pkg.sv
package pctd_pkg;

    typedef struct packed {
        logic        mode;
        logic [7:0]  entry_index;
        logic [23:0] entry_symbol;
        logic [5:0]  entry_length;
        logic [31:0] entry_code;
        logic [7:0]  data_byte;
        logic [3:0]  valid_bits;
        logic        final_byte;
    } t_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       stream_end;
        logic       bad_code;
    } t_result;

    typedef struct packed {
        logic [23:0] symbol;
        logic [5:0]  length;
        logic [31:0] code;
    } t_entry;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BIT,
        ST_SCAN,
        ST_FINISH,
        ST_EMIT
    } t_state;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_DATA = 1'b1;

    localparam logic [1:0] SYM_NIBBLE = 2'd0;
    localparam logic [1:0] SYM_ONE    = 2'd1;
    localparam logic [1:0] SYM_TWO    = 2'd2;
    localparam logic [1:0] SYM_THREE  = 2'd3;

    localparam logic CFG_SYMBOL_MODE = 1'b0;
    localparam logic CFG_PAD_BYTES   = 1'b1;

    localparam logic [1:0] SYMBOL_MODE_RESET = SYM_ONE;
    localparam logic [1:0] PAD_BYTES_RESET   = 2'd0;

endpackage

FILE: src/prefix_code_table_decoder.sv
// Load word: written to the code table when taken; busy stays low. Data word: per valid
// bit a shift step and a table scan (one entry per cycle through the table RAM read port,
// up to the first hit), plus output runs and a closing step; busy stays high throughout.
// Output bytes come one per cycle on o_result_strobe; the receiver cannot stall.
// Reset (i_rst_n low, synchronous) clears all control state, then a clearing pass
// empties the code table while busy is high.
`include "prefix_code_table_decoder_macros.svh"

module prefix_code_table_decoder #(
    parameter int TABLE_ENTRIES = 256,
    parameter int MAX_CODE_BITS = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  pctd_pkg::t_item  i_item,
    output logic             busy,
    output logic             o_result_strobe,
    output pctd_pkg::t_result o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic             i_cfg_index,
    input  logic [1:0]       i_cfg_data
);
    import pctd_pkg::*;

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int LW = $clog2(MAX_CODE_BITS + 1);
    localparam int EW = $bits(t_entry);

    t_state                   r_state, n_state;
    logic [AW-1:0]            r_addr, n_addr;
    logic                     r_issue_on, n_issue_on;
    logic                     r_rd_pend, n_rd_pend;
    logic                     r_rd_last, n_rd_last;
    logic [7:0]               r_byte, n_byte;
    logic [3:0]               r_bits_left, n_bits_left;
    logic                     r_fin, n_fin;
    logic [MAX_CODE_BITS-1:0] r_pcode, n_pcode;
    logic [LW-1:0]            r_plen, n_plen;
    logic                     r_nib_pend, n_nib_pend;
    logic [3:0]               r_hi_nib, n_hi_nib;
    logic                     r_grp_vld, n_grp_vld;
    logic [23:0]              r_grp_data, n_grp_data;
    logic [1:0]               r_grp_cnt, n_grp_cnt;
    logic                     r_grp_bad, n_grp_bad;
    logic [23:0]              r_e_data, n_e_data;
    logic [1:0]               r_e_rem, n_e_rem;
    logic                     r_e_bad, n_e_bad;
    logic                     r_e_last, n_e_last;
    logic                     r_e_stream, n_e_stream;
    logic [1:0]               r_sym_mode;
    logic [1:0]               r_pad;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [EW-1:0]            ram_wdata;
    logic                     ram_re;
    logic [EW-1:0]            ram_rdata;
    t_entry                   rd_entry;
    t_entry                   ld_entry;
    logic                     hit;
    logic                     accept;
    logic                     ld_in_range;

    logic                     push;
    logic [23:0]              push_data;
    logic [1:0]               push_cnt;
    logic                     push_bad;

    assign accept      = start && !busy;
    assign ld_in_range = ({24'd0, i_item.entry_index} < 32'(TABLE_ENTRIES));
    assign o_cfg_ready = 1'b1;

    always_comb begin
        ld_entry.symbol = i_item.entry_symbol;
        ld_entry.length = i_item.entry_length;
        ld_entry.code   = i_item.entry_code;
    end

    always_comb begin
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = accept && (i_item.mode == MODE_LOAD) && ld_in_range;
            ram_waddr = AW'(i_item.entry_index);
            ram_wdata = ld_entry;
        end
    end

    assign ram_re   = (r_state == ST_SCAN) && r_issue_on;
    assign rd_entry = t_entry'(ram_rdata);

    pctd_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    pctd_match #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_match (
        .i_entry (rd_entry),
        .i_pcode (r_pcode),
        .i_plen  (r_plen),
        .o_hit   (hit)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sym_mode <= SYMBOL_MODE_RESET;
            r_pad      <= PAD_BYTES_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SYMBOL_MODE: r_sym_mode <= i_cfg_data;
                CFG_PAD_BYTES:   r_pad      <= i_cfg_data;
                default:         r_pad      <= r_pad;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_issue_on  <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_rd_last   <= 1'b0;
            r_bits_left <= '0;
            r_fin       <= 1'b0;
            r_pcode     <= '0;
            r_plen      <= '0;
            r_nib_pend  <= 1'b0;
            r_hi_nib    <= '0;
            r_grp_vld   <= 1'b0;
            r_e_rem     <= '0;
            r_e_last    <= 1'b0;
            r_e_stream  <= 1'b0;
            r_e_bad     <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_issue_on  <= n_issue_on;
            r_rd_pend   <= n_rd_pend;
            r_rd_last   <= n_rd_last;
            r_bits_left <= n_bits_left;
            r_fin       <= n_fin;
            r_pcode     <= n_pcode;
            r_plen      <= n_plen;
            r_nib_pend  <= n_nib_pend;
            r_hi_nib    <= n_hi_nib;
            r_grp_vld   <= n_grp_vld;
            r_e_rem     <= n_e_rem;
            r_e_last    <= n_e_last;
            r_e_stream  <= n_e_stream;
            r_e_bad     <= n_e_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte     <= n_byte;
        r_grp_data <= n_grp_data;
        r_grp_cnt  <= n_grp_cnt;
        r_grp_bad  <= n_grp_bad;
        r_e_data   <= n_e_data;
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_issue_on  = r_issue_on;
        n_rd_pend   = 1'b0;
        n_rd_last   = r_rd_last;
        n_byte      = r_byte;
        n_bits_left = r_bits_left;
        n_fin       = r_fin;
        n_pcode     = r_pcode;
        n_plen      = r_plen;
        n_nib_pend  = r_nib_pend;
        n_hi_nib    = r_hi_nib;
        n_grp_vld   = r_grp_vld;
        n_grp_data  = r_grp_data;
        n_grp_cnt   = r_grp_cnt;
        n_grp_bad   = r_grp_bad;
        n_e_data    = r_e_data;
        n_e_rem     = r_e_rem;
        n_e_bad     = r_e_bad;
        n_e_last    = r_e_last;
        n_e_stream  = r_e_stream;
        push        = 1'b0;
        push_data   = '0;
        push_cnt    = 2'd1;
        push_bad    = 1'b0;

        case (r_state)
            ST_CLEAR: begin
                n_addr = r_addr + AW'(1);
                if (r_addr == AW'(TABLE_ENTRIES - 1)) begin
                    n_addr  = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && (i_item.mode == MODE_DATA)) begin
                    n_byte      = i_item.data_byte;
                    n_bits_left = (i_item.valid_bits > 4'd8) ? 4'd8 : i_item.valid_bits;
                    n_fin       = i_item.final_byte;
                    n_state     = ST_BIT;
                end
            end
            ST_BIT: begin
                if (r_bits_left == 4'd0) begin
                    n_state = ST_FINISH;
                end else begin
                    n_pcode     = {r_pcode[MAX_CODE_BITS-2:0], r_byte[7]};
                    n_byte      = {r_byte[6:0], 1'b0};
                    n_bits_left = r_bits_left - 4'd1;
                    n_plen      = r_plen + LW'(1);
                    n_addr      = '0;
                    n_issue_on  = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_issue_on) begin
                    n_rd_pend = 1'b1;
                    n_rd_last = (r_addr == AW'(TABLE_ENTRIES - 1));
                    if (r_addr == AW'(TABLE_ENTRIES - 1)) begin
                        n_issue_on = 1'b0;
                    end else begin
                        n_addr = r_addr + AW'(1);
                    end
                end
                if (r_rd_pend && hit) begin
                    n_issue_on = 1'b0;
                    n_rd_pend  = 1'b0;
                    n_pcode    = '0;
                    n_plen     = '0;
                    n_state    = ST_BIT;
                    case (r_sym_mode)
                        SYM_NIBBLE: begin
                            if (r_nib_pend) begin
                                push       = 1'b1;
                                push_data  = {16'd0, r_hi_nib, rd_entry.symbol[3:0]};
                                n_nib_pend = 1'b0;
                            end else begin
                                n_hi_nib   = rd_entry.symbol[3:0];
                                n_nib_pend = 1'b1;
                            end
                        end
                        SYM_ONE: begin
                            push      = 1'b1;
                            push_data = rd_entry.symbol;
                        end
                        SYM_TWO: begin
                            push      = 1'b1;
                            push_data = rd_entry.symbol;
                            push_cnt  = 2'd2;
                        end
                        default: begin
                            push      = 1'b1;
                            push_data = rd_entry.symbol;
                            push_cnt  = 2'd3;
                        end
                    endcase
                end else if (r_rd_pend && r_rd_last) begin
                    n_issue_on = 1'b0;
                    n_rd_pend  = 1'b0;
                    n_state    = ST_BIT;
                    if (r_plen >= LW'(MAX_CODE_BITS)) begin
                        push     = 1'b1;
                        push_bad = 1'b1;
                        n_pcode  = '0;
                        n_plen   = '0;
                    end
                end
            end
            ST_FINISH: begin
                if (r_fin) begin
                    n_pcode    = '0;
                    n_plen     = '0;
                    n_nib_pend = 1'b0;
                end
                if (r_grp_vld) begin
                    n_e_data   = r_grp_data;
                    n_e_bad    = r_grp_bad;
                    n_e_last   = 1'b1;
                    n_e_stream = r_fin;
                    n_e_rem    = r_grp_cnt;
                    if (r_fin && !r_grp_bad && (r_pad != 2'd0) && (r_pad < r_grp_cnt)) begin
                        n_e_rem = r_grp_cnt - r_pad;
                    end
                    n_grp_vld = 1'b0;
                    n_state   = ST_EMIT;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                n_e_rem = r_e_rem - 2'd1;
                if (r_e_rem == 2'd1) begin
                    n_state = r_e_last ? ST_IDLE : ST_BIT;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // flush the held group before taking the new one
        if (push) begin
            if (r_grp_vld) begin
                n_e_data   = r_grp_data;
                n_e_bad    = r_grp_bad;
                n_e_rem    = r_grp_cnt;
                n_e_last   = 1'b0;
                n_e_stream = 1'b0;
                n_state    = ST_EMIT;
            end
            n_grp_vld  = 1'b1;
            n_grp_data = push_data;
            n_grp_cnt  = push_cnt;
            n_grp_bad  = push_bad;
        end
    end

    assign busy            = (r_state != ST_IDLE);
    assign o_result_strobe = (r_state == ST_EMIT);

    always_comb begin
        case (r_e_rem)
            2'd3:    o_result.out_byte = r_e_data[23:16];
            2'd2:    o_result.out_byte = r_e_data[15:8];
            default: o_result.out_byte = r_e_data[7:0];
        endcase
        if (r_e_bad) begin
            o_result.out_byte = 8'd0;
        end
        o_result.last_of_run = r_e_last && (r_e_rem == 2'd1);
        o_result.stream_end  = r_e_stream && (r_e_rem == 2'd1);
        o_result.bad_code    = r_e_bad;
    end

    `PCTD_ASSERT_SAME(a_strobe_busy, o_result_strobe, busy, "result strobe while idle")
    `PCTD_ASSERT_SAME(a_bad_zero, o_result_strobe && o_result.bad_code, o_result.out_byte == 8'd0, "bad code word carries data")
    `PCTD_ASSERT_SAME(a_end_last, o_result_strobe && o_result.stream_end, o_result.last_of_run, "stream end without last of run")
    `PCTD_ASSERT_NEXT(a_data_busy, start && !busy && (i_item.mode == MODE_DATA), busy, "data word taken without going busy")

endmodule

FILE: src/pctd_ram.sv
module pctd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/pctd_match.sv
module pctd_match #(
    parameter int MAX_CODE_BITS = 32
) (
    input  pctd_pkg::t_entry                      i_entry,
    input  logic [MAX_CODE_BITS-1:0]              i_pcode,
    input  logic [$clog2(MAX_CODE_BITS+1)-1:0]    i_plen,
    output logic                                  o_hit
);
    import pctd_pkg::*;

    logic [31:0] mask;

    always_comb begin
        if (i_entry.length >= 6'd32) begin
            mask = '1;
        end else begin
            mask = (32'd1 << i_entry.length) - 32'd1;
        end
    end

    assign o_hit = (i_entry.length != 6'd0)
                && (i_entry.length == 6'(i_plen))
                && ((i_entry.code & mask) == 32'(i_pcode));

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import pctd_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 10;
    localparam int TABLE_SIZE   = 256;
    localparam int MAX_BITS     = 32;
    localparam int DRAIN_CYCLES = 8 * (TABLE_SIZE + 2) + 64;
    localparam int RANDOM_WORDS = 200;
    localparam int MIN_BYTES    = 48;
    localparam int TIMEOUT_NS   = 30_000_000;

    logic    i_clk = 1'b0;
    logic    i_rst_n;
    logic    start;
    t_item   i_item;
    logic    busy;
    logic    o_result_strobe;
    t_result o_result;
    logic    i_cfg_valid;
    logic    o_cfg_ready;
    logic    i_cfg_index;
    logic [1:0] i_cfg_data;

    // decoder image: table, bit gatherer and settings
    logic [31:0] code_mem [TABLE_SIZE];
    logic [5:0]  len_mem  [TABLE_SIZE];
    logic [23:0] sym_mem  [TABLE_SIZE];
    logic [31:0] acc_code;
    int          acc_len;
    bit          nib_pend;
    logic [3:0]  nib_hi;
    logic [1:0]  sym_mode;
    logic [1:0]  pad_cnt;

    t_result bytes_due [$];

    // live code of the current random phase
    logic [31:0] cur_code [$];
    int          cur_len [$];
    int          live_slots [$];

    bit       idle_on = 1'b1;
    bit [3:0] modes_seen;
    bit [3:0] pads_seen;
    int       n_items;
    int       n_data;
    int       n_checked;
    int       n_bad;
    int       n_ends;
    int       n_errors;

    prefix_code_table_decoder #(
        .TABLE_ENTRIES (TABLE_SIZE),
        .MAX_CODE_BITS (MAX_BITS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .i_item          (i_item),
        .busy            (busy),
        .o_result_strobe (o_result_strobe),
        .o_result        (o_result),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    function automatic t_result byte_result(input logic [7:0] b, input logic bad);
        t_result r;
        r          = '0;
        r.out_byte = b;
        r.bad_code = bad;
        return r;
    endfunction

    function automatic int match_slot();
        logic [63:0] mask;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (len_mem[i] != 0 && len_mem[i] == acc_len && len_mem[i] <= MAX_BITS) begin
                mask = (64'd1 << len_mem[i]) - 64'd1;
                if (({32'd0, code_mem[i]} & mask) == {32'd0, acc_code}) begin
                    return i;
                end
            end
        end
        return -1;
    endfunction

    function automatic void decode_word(input t_item w);
        t_result     run [$];
        t_result     r;
        int          vb;
        int          slot;
        int          first;
        int          last_start;
        int          last_len;
        logic [23:0] sym;
        if (w.mode == MODE_LOAD) begin
            sym_mem[w.entry_index]  = w.entry_symbol;
            len_mem[w.entry_index]  = w.entry_length;
            code_mem[w.entry_index] = w.entry_code;
            return;
        end
        vb         = (w.valid_bits > 8) ? 8 : int'(w.valid_bits);
        last_start = 0;
        last_len   = 0;
        for (int b = 0; b < vb; b++) begin
            acc_code = {acc_code[30:0], w.data_byte[7 - b]};
            acc_len++;
            slot = match_slot();
            if (slot >= 0) begin
                sym      = sym_mem[slot];
                first    = run.size();
                acc_code = '0;
                acc_len  = 0;
                case (sym_mode)
                    SYM_NIBBLE: begin
                        if (nib_pend) begin
                            run.push_back(byte_result({nib_hi, sym[3:0]}, 1'b0));
                            nib_pend = 1'b0;
                        end else begin
                            nib_hi   = sym[3:0];
                            nib_pend = 1'b1;
                        end
                    end
                    SYM_ONE: begin
                        run.push_back(byte_result(sym[7:0], 1'b0));
                    end
                    SYM_TWO: begin
                        run.push_back(byte_result(sym[15:8], 1'b0));
                        run.push_back(byte_result(sym[7:0], 1'b0));
                    end
                    default: begin
                        run.push_back(byte_result(sym[23:16], 1'b0));
                        run.push_back(byte_result(sym[15:8], 1'b0));
                        run.push_back(byte_result(sym[7:0], 1'b0));
                    end
                endcase
                if (run.size() > first) begin
                    last_start = first;
                    last_len   = run.size() - first;
                end
            end else if (acc_len >= MAX_BITS) begin
                run.push_back(byte_result(8'h00, 1'b1));
                last_len = 0;
                acc_code = '0;
                acc_len  = 0;
            end
        end
        if (w.final_byte) begin
            // drop leading pad bytes of the closing symbol
            if (last_len > 0 && last_start + last_len == run.size() &&
                    pad_cnt < last_len && pad_cnt > 0) begin
                repeat (pad_cnt) run.delete(last_start);
            end
            acc_code = '0;
            acc_len  = 0;
            nib_pend = 1'b0;
        end
        if (run.size() > 0) begin
            r             = run[run.size() - 1];
            r.last_of_run = 1'b1;
            r.stream_end  = w.final_byte;
            run[run.size() - 1] = r;
        end
        foreach (run[i]) bytes_due.push_back(run[i]);
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            n_errors++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_result_strobe) begin
            if (bytes_due.size() == 0) begin
                $display("%0t: unexpected word, expected none, actual %h", $time, o_result);
                n_errors++;
            end else begin
                want = bytes_due.pop_front();
                check_field("out_byte", want.out_byte, o_result.out_byte);
                check_field("last_of_run", want.last_of_run, o_result.last_of_run);
                check_field("stream_end", want.stream_end, o_result.stream_end);
                check_field("bad_code", want.bad_code, o_result.bad_code);
            end
            n_checked++;
            if (o_result.bad_code) n_bad++;
            if (o_result.stream_end) n_ends++;
        end
    end

    function automatic t_item load_word(input logic [7:0] idx, input logic [23:0] sym,
                                        input logic [5:0] len, input logic [31:0] code);
        t_item w;
        w.mode         = MODE_LOAD;
        w.entry_index  = idx;
        w.entry_symbol = sym;
        w.entry_length = len;
        w.entry_code   = code;
        w.data_byte    = $urandom_range(0, 255);
        w.valid_bits   = $urandom_range(0, 15);
        w.final_byte   = $urandom_range(0, 1);
        return w;
    endfunction

    function automatic t_item data_word(input logic [7:0] b, input logic [3:0] vb,
                                        input logic fin);
        t_item w;
        w.mode         = MODE_DATA;
        w.entry_index  = $urandom_range(0, 255);
        w.entry_symbol = $urandom_range(0, 24'hFFFFFF);
        w.entry_length = $urandom_range(0, 63);
        w.entry_code   = $urandom;
        w.data_byte    = b;
        w.valid_bits   = vb;
        w.final_byte   = fin;
        return w;
    endfunction

    task automatic send_word(input t_item w);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            if ($urandom_range(0, 1) == 1) begin
                do @(posedge i_clk); while (busy);
            end
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= w;
        do @(posedge i_clk); while (busy);
        decode_word(w);
        n_items++;
        if (w.mode == MODE_DATA) n_data++;
    endtask

    // hold off until every due word is out; full also waits out a silent item
    task automatic settle(input bit full);
        start <= 1'b0;
        do @(posedge i_clk); while (bytes_due.size() != 0);
        if (full) repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_settings(input logic [1:0] mode_v, input logic [1:0] pad_v);
        settle(1'b1);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_SYMBOL_MODE;
        i_cfg_data  <= mode_v;
        do @(posedge i_clk); while (!o_cfg_ready);
        sym_mode = mode_v;
        i_cfg_index <= CFG_PAD_BYTES;
        i_cfg_data  <= pad_v;
        do @(posedge i_clk); while (!o_cfg_ready);
        pad_cnt = pad_v;
        i_cfg_valid <= 1'b0;
        modes_seen[mode_v] = 1'b1;
        pads_seen[pad_v]   = 1'b1;
    endtask

    task automatic test_empty_table();
        send_word(data_word(8'hFF, 4'd8, 1'b0));
        send_word(data_word(8'hFF, 4'd8, 1'b0));
        send_word(data_word(8'h00, 4'd8, 1'b0));
        send_word(data_word(8'h5A, 4'd8, 1'b0));
    endtask

    task automatic test_directed_codes();
        send_word(load_word(8'd0, 24'hFFFFFF, 6'd33, 32'hFFFFFFFF));
        send_word(load_word(8'd1, 24'h000000, 6'd63, 32'h00000000));
        send_word(load_word(8'd2, 24'h123456, 6'd0, 32'h00000000));
        send_word(load_word(8'd7, 24'hABCDEF, 6'd1, 32'hFFFFFFFE));
        send_word(load_word(8'd9, 24'h00C3A5, 6'd2, 32'h00000002));
        send_word(load_word(8'd200, 24'h5A5A5A, 6'd2, 32'h00000002));
        send_word(load_word(8'd255, 24'h0F1E2D, 6'd32, 32'hFFFFFFFF));
        send_word(data_word(8'h24, 4'd8, 1'b0));
        send_word(data_word(8'hFF, 4'd15, 1'b0));
        send_word(data_word(8'hFF, 4'd8, 1'b0));
        send_word(data_word(8'hFF, 4'd8, 1'b0));
        send_word(data_word(8'hFF, 4'd8, 1'b0));
        send_word(data_word(8'h40, 4'd3, 1'b1));
    endtask

    task automatic test_symbol_modes();
        logic [1:0] modes [4] = '{SYM_NIBBLE, SYM_TWO, SYM_THREE, SYM_TWO};
        logic [1:0] pads  [4] = '{2'd0, 2'd1, 2'd2, 2'd2};
        for (int i = 0; i < 4; i++) begin
            write_settings(modes[i], pads[i]);
            send_word(data_word(8'h24, 4'd8, 1'b0));
            if (modes[i] == SYM_NIBBLE) begin
                send_word(data_word(8'h00, 4'd1, 1'b1));
                send_word(data_word(8'h5A, 4'd0, 1'b1));
            end else begin
                send_word(data_word(8'h40, 4'd3, 1'b1));
            end
        end
    endtask

    task automatic load_code_table();
        bit          taken [TABLE_SIZE];
        logic [63:0] c;
        logic [63:0] m;
        int          len;
        int          nl;
        int          slot;
        int          s;
        foreach (live_slots[i]) begin
            send_word(load_word(live_slots[i], $urandom_range(0, 24'hFFFFFF), 6'd0, $urandom));
        end
        live_slots.delete();
        cur_code.delete();
        cur_len.delete();
        len = $urandom_range(1, 3);
        c   = '0;
        for (int i = 0; i < $urandom_range(2, 12); i++) begin
            if (i > 0) begin
                nl = len;
                if ($urandom_range(0, 15) == 0) begin
                    nl = $urandom_range(len, MAX_BITS);
                end else if ($urandom_range(0, 2) == 0) begin
                    nl = len + $urandom_range(1, 2);
                end
                if (nl > MAX_BITS) nl = MAX_BITS;
                c   = (c + 64'd1) << (nl - len);
                len = nl;
                if ((c >> len) != 0) break;
            end
            do slot = $urandom_range(0, TABLE_SIZE - 1); while (taken[slot]);
            taken[slot] = 1'b1;
            m = (64'd1 << len) - 64'd1;
            cur_code.push_back(c[31:0]);
            cur_len.push_back(len);
            live_slots.push_back(slot);
            send_word(load_word(slot, $urandom_range(0, 24'hFFFFFF), len,
                                32'(c | ({32'd0, $urandom} & ~m))));
        end
        // shadow an existing code in another slot
        if ($urandom_range(0, 2) == 0) begin
            s = $urandom_range(0, cur_code.size() - 1);
            do slot = $urandom_range(0, TABLE_SIZE - 1); while (taken[slot]);
            taken[slot] = 1'b1;
            live_slots.push_back(slot);
            send_word(load_word(slot, $urandom_range(0, 24'hFFFFFF), cur_len[s], cur_code[s]));
        end
        if ($urandom_range(0, 3) == 0) begin
            do slot = $urandom_range(0, TABLE_SIZE - 1); while (taken[slot]);
            taken[slot] = 1'b1;
            live_slots.push_back(slot);
            send_word(load_word(slot, $urandom_range(0, 24'hFFFFFF),
                                $urandom_range(MAX_BITS + 1, 63), $urandom));
        end
    endtask

    task automatic send_stream(input bit whole);
        bit   bits [$];
        int   s;
        int   j;
        int   nb;
        logic [7:0] b;
        logic [3:0] vb;
        bit   fin;
        repeat ($urandom_range(1, 10)) begin
            s = $urandom_range(0, cur_code.size() - 1);
            for (j = cur_len[s] - 1; j >= 0; j--) bits.push_back(cur_code[s][j]);
        end
        if (!whole) begin
            case ($urandom_range(0, 2))
                0: begin
                    j       = $urandom_range(0, bits.size() - 1);
                    bits[j] = ~bits[j];
                end
                1: begin
                    if (bits.size() > 1) begin
                        repeat ($urandom_range(1, bits.size() - 1)) void'(bits.pop_back());
                    end
                end
                default: begin
                    repeat ($urandom_range(1, 12)) bits.push_back($urandom_range(0, 1));
                end
            endcase
        end
        fin = whole || $urandom_range(0, 1) == 1;
        while (bits.size() > 0) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(data_word($urandom_range(0, 255), 4'd0, 1'b0));
            end
            nb = (bits.size() > 8) ? 8 : bits.size();
            b  = $urandom_range(0, 255);
            for (j = 0; j < nb; j++) b[7 - j] = bits.pop_front();
            vb = (nb == 8 && $urandom_range(0, 3) == 0) ? $urandom_range(9, 15) : nb;
            send_word(data_word(b, vb, fin && bits.size() == 0));
        end
    endtask

    task automatic test_random_streams();
        int first;
        first = n_items;
        while (n_items - first < RANDOM_WORDS || n_checked < MIN_BYTES) begin
            if (n_items - first > RANDOM_WORDS * 3 / 4) idle_on = 1'b0;
            write_settings($urandom_range(0, 3), $urandom_range(0, 2));
            load_code_table();
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 9))
                    0: begin
                        repeat ($urandom_range(1, 4)) begin
                            send_word(data_word($urandom_range(0, 255), $urandom_range(0, 15),
                                                $urandom_range(0, 1)));
                        end
                    end
                    1, 2:    send_stream(1'b0);
                    default: send_stream(1'b1);
                endcase
                if ($urandom_range(0, 5) == 0) settle(1'b0);
            end
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_SYMBOL_MODE;
        i_cfg_data  <= '0;
        foreach (len_mem[i]) begin
            len_mem[i]  = '0;
            code_mem[i] = '0;
            sym_mem[i]  = '0;
        end
        acc_code = '0;
        acc_len  = 0;
        nib_pend = 1'b0;
        nib_hi   = '0;
        sym_mode = SYMBOL_MODE_RESET;
        pad_cnt  = PAD_BYTES_RESET;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_directed_codes();
        test_symbol_modes();
        test_random_streams();
        settle(1'b1);

        $display("tb_top: %0d words sent (%0d compressed bytes), %0d output words checked",
                 n_items, n_data, n_checked);
        $display("tb_top: %0d bad-code flags, %0d stream ends, symbol modes %b, pad counts %b",
                 n_bad, n_ends, modes_seen, pads_seen);
        if (n_errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule
